/* sv/sitoa_pkg.sv */
// Shared constants and types for the signed integer to decimal ASCII converter.
package sitoa_pkg;

	// Width of the input integer
	localparam int VALUE_BITS = 32;
	// Decimal digits needed for a magnitude up to 2^(VALUE_BITS-1): floor(log10) + 1
	localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	// Character field and stream bus widths
	localparam int CHAR_W      = 6;
	localparam int OUT_DATA_W  = ((CHAR_W + 7) / 8) * 8;
	localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

	// Operation applied to every digit cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_MOVE
	} cell_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

/* sv/signed_int_to_decimal_ascii_top.sv */
// Top level: signed integer to decimal ASCII character stream converter.
// Each accepted 32-bit signed integer is emitted as its decimal text, one ASCII
// character per output transaction, most significant first: a minus sign for
// negative values, then the digits without leading zeros (zero gives "0"); tlast
// marks the final character. The most negative value prints in full. An item is
// accepted, converted one bit per cycle by shifting its magnitude through a chain
// of ten BCD digit cells, then its leading zeros are moved out of the chain (at
// most nine), the sign is decided, and the characters are loaded into the output
// register whenever it is free or the sink is ready. Skipped zeros plus digits
// always make ten. A new integer is accepted once the previous text has been
// handed to the output register.
module signed_int_to_decimal_ascii_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sitoa_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sitoa_pkg::OUT_DATA_W-1:0]  m_tdata,   // [5:0] char_code, rest zero
	output logic                              m_tlast    // is_last
);
	import sitoa_pkg::*;

	state_t                  state_q, state_d;
	cell_op_t                cell_op;
	logic [VALUE_BITS-1:0]   mag_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       out_char_q;
	logic                    out_last_q;
	logic                    out_load;
	logic [CHAR_W-1:0]       out_char_d;
	logic                    out_last_d;
	logic                    slot_free;
	logic                    in_accept;
	logic                    in_neg;
	logic [VALUE_BITS-1:0]   in_raw;
	logic [VALUE_BITS-1:0]   in_mag;
	logic [3:0]              top_digit;

	// Chain links: carry[i] / dig[i] enter cell i, cell i drives carry[i+1] / dig[i+1]
	logic [NUM_DIGITS:0]     carry;
	logic [3:0]              dig [NUM_DIGITS+1];

	assign in_raw    = s_tdata[VALUE_BITS-1:0];
	assign in_neg    = in_raw[VALUE_BITS-1];
	assign in_mag    = in_neg ? (~in_raw + VALUE_BITS'(1)) : in_raw;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign carry[0]  = mag_q[VALUE_BITS-1];
	assign dig[0]    = 4'd0;
	assign top_digit = dig[NUM_DIGITS];

	// Digit cell chain, least significant digit first
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		sitoa_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (cell_op),
			.shift_in  (carry[i]),
			.digit_in  (dig[i]),
			.shift_out (carry[i+1]),
			.digit     (dig[i+1])
		);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, chain operation and output load
	always_comb begin
		state_d    = state_q;
		cell_op    = CELL_HOLD;
		out_load   = 1'b0;
		out_char_d = ASCII_ZERO;
		out_last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cell_op = CELL_CLEAR;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_op = CELL_DABBLE;
				if (cnt_q == CNT_W'(1)) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && rem_q != REM_W'(1)) begin
					cell_op = CELL_MOVE;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_char_d = ASCII_MINUS;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_char_d = ASCII_ZERO + CHAR_W'(top_digit);
					out_last_d = (rem_q == REM_W'(1));
					cell_op    = CELL_MOVE;
					if (rem_q == REM_W'(1)) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Magnitude shifter and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (in_accept) begin
			cnt_q <= CNT_W'(VALUE_BITS);
			neg_q <= in_neg;
		end else if (cell_op == CELL_DABBLE) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q <= in_mag;
		end else if (cell_op == CELL_DABBLE) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Count of digits still in the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (in_accept) begin
			rem_q <= REM_W'(NUM_DIGITS);
		end else if (cell_op == CELL_MOVE) begin
			rem_q <= rem_q - REM_W'(1);
		end
	end

	// Output register: hold until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char_q};
	assign m_tlast  = out_last_q;

	// The digit chain is wide enough: nothing ever shifts out of the top cell
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_op == CELL_DABBLE) |-> !carry[NUM_DIGITS])
		else $error("digit chain overflow");

	// Every emitted digit is a decimal digit
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= 4'd9))
		else $error("non-decimal digit reached the output");

	// An accepted integer starts conversion on the next cycle
	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_CONV && cnt_q == CNT_W'(VALUE_BITS)))
		else $error("conversion did not start");

	// At least one digit remains while text is being produced
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_SIGN || state_q == ST_EMIT)
		|-> (rem_q != '0))
		else $error("digit count underflow");

	// The sign is loaded only for negative values
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_char_d == ASCII_MINUS) |-> (neg_q && !out_last_d))
		else $error("unexpected minus sign");

endmodule

/* sv/sitoa_bcd_cell.sv */
// One BCD digit cell of the shift-and-add-3 chain; also moves digits upward for output.
module sitoa_bcd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sitoa_pkg::cell_op_t op,
	input  logic              shift_in,   // bit from the next lower cell
	input  logic [3:0]        digit_in,   // digit of the next lower cell
	output logic              shift_out,  // bit handed to the next higher cell
	output logic [3:0]        digit
);
	import sitoa_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add 3 to digits of five or more before the shift
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign shift_out = (op == CELL_DABBLE) ? adj[3] : 1'b0;
	assign digit     = digit_q;

	// Update the digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else begin
			unique case (op)
				CELL_HOLD:   digit_q <= digit_q;
				CELL_CLEAR:  digit_q <= 4'd0;
				CELL_DABBLE: digit_q <= {adj[2:0], shift_in};
				CELL_MOVE:   digit_q <= digit_in;
				default:     digit_q <= digit_q;
			endcase
		end
	end

endmodule
